FILE: design/gmo_pkg.sv
// shared constants, codes and structs for the group majority opinion core
// no dependencies
package gmo_pkg;

  localparam int AGENTS_MAX = 1024;
  localparam int GROUP_MAX  = 16;

  localparam int AIDX_W   = $clog2(AGENTS_MAX);
  localparam int GIDX_W   = $clog2(GROUP_MAX);
  localparam int GCNT_W   = GIDX_W + 1;
  localparam int SUM_W    = GCNT_W + 1;
  localparam int DELTA_W  = GCNT_W + 2;
  localparam int VAL_W    = 32;
  localparam int ROUNDS_W = 16;
  localparam int ACNT_W   = 11;
  localparam int OP_W     = 2;
  localparam int CAUSE_W  = 2;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_MAX_ROUNDS  = 2'd0;
  localparam logic [1:0] REG_SELF_INFL   = 2'd1;
  localparam logic [1:0] REG_AGENT_COUNT = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_MEMBER = 2'd1,
    OP_COUNT  = 2'd2
  } op_t;

  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_LIMIT = 2'd0,
    CAUSE_NEG   = 2'd1,
    CAUSE_POS   = 2'd2
  } cause_t;

  typedef struct packed {
    logic [ROUNDS_W-1:0] max_rounds;
    logic                self_influence;
    logic [ACNT_W-1:0]   agent_count;
  } cfg_t;

  typedef struct packed {
    logic                    we;
    logic [AIDX_W-1:0]       waddr;
    logic signed [VAL_W-1:0] wdata;
    logic [AIDX_W-1:0]       raddr;
  } store_req_t;

  typedef struct packed {
    logic              ins;
    logic [AIDX_W-1:0] ins_idx;
    logic              clear;
    logic [GIDX_W-1:0] sel;
    logic              sgn_we;
    logic [GIDX_W-1:0] sgn_sel;
    logic              sgn_pos;
  } mbr_ctl_t;

  typedef struct packed {
    logic [GCNT_W-1:0] total;
    logic [AIDX_W-1:0] idx;
    logic [GCNT_W-1:0] mult;
    logic              sgn_pos;
  } mbr_stat_t;

endpackage

FILE: design/gmo_if.sv
// valid/ready channel interfaces for request items and result items
// depends on gmo_pkg
interface gmo_req_if;
  import gmo_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [AIDX_W-1:0]       agent_index;
  logic signed [VAL_W-1:0] agent_value;
  logic                    last_member;
  modport source(output valid, op, agent_index, agent_value, last_member, input ready);
  modport sink(input valid, op, agent_index, agent_value, last_member, output ready);
endinterface

interface gmo_rsp_if;
  import gmo_pkg::*;
  logic                valid;
  logic                ready;
  logic [ROUNDS_W-1:0] rounds_done;
  logic [CAUSE_W-1:0]  end_cause;
  logic [ACNT_W-1:0]   negative_count;
  modport source(output valid, rounds_done, end_cause, negative_count, input ready);
  modport sink(input valid, rounds_done, end_cause, negative_count, output ready);
endinterface

FILE: design/gmo_store.sv
// opinion memory: one write port, one read port with registered read data
// depends on gmo_pkg
module gmo_store (
  input  logic                             clk,
  input  gmo_pkg::store_req_t              req,
  output logic signed [gmo_pkg::VAL_W-1:0] rdata
);
  import gmo_pkg::*;

  logic signed [VAL_W-1:0] mem [AGENTS_MAX];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

FILE: design/gmo_members.sv
// member list of the open group, with per-entry multiplicity and sign flags
// depends on gmo_pkg
module gmo_members (
  input  logic               clk,
  input  logic               rst,
  input  gmo_pkg::mbr_ctl_t  ctl,
  output gmo_pkg::mbr_stat_t stat
);
  import gmo_pkg::*;

  logic [AIDX_W-1:0] list [GROUP_MAX];
  logic [GCNT_W-1:0] mult [GROUP_MAX];
  logic [GROUP_MAX-1:0] sgn;
  logic [GCNT_W-1:0] total;
  logic [GROUP_MAX-1:0] match;
  logic [GCNT_W-1:0] dup_cnt;
  logic room;

  always_comb begin
    for (int k = 0; k < GROUP_MAX; k++) begin
      match[k] = (GCNT_W'(k) < total) && (list[k] == ctl.ins_idx);
    end
    dup_cnt = GCNT_W'($countones(match));
    room    = total < GCNT_W'(GROUP_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (ctl.clear) begin
      total <= '0;
    end else if (ctl.ins && room) begin
      total <= total + GCNT_W'(1);
    end
  end

  // payload side: list, multiplicities and signs need no reset
  always_ff @(posedge clk) begin
    if (ctl.ins && room) begin
      for (int k = 0; k < GROUP_MAX; k++) begin
        if (match[k]) begin
          mult[k] <= mult[k] + GCNT_W'(1);
        end
      end
      list[total[GIDX_W-1:0]] <= ctl.ins_idx;
      mult[total[GIDX_W-1:0]] <= dup_cnt + GCNT_W'(1);
    end
    if (ctl.sgn_we) begin
      sgn[ctl.sgn_sel] <= ctl.sgn_pos;
    end
  end

  assign stat.total   = total;
  assign stat.idx     = list[ctl.sel];
  assign stat.mult    = mult[ctl.sel];
  assign stat.sgn_pos = sgn[ctl.sel];

endmodule

FILE: design/gmo_ctrl.sv
// sequencer: takes items, runs gather/update rounds and negative counts
// through the opinion memory; depends on gmo_pkg and gmo_if
module gmo_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  gmo_req_if.sink                         req,
  gmo_rsp_if.source                       rsp,
  input  gmo_pkg::cfg_t                   cfg,
  output gmo_pkg::store_req_t             store,
  input  logic signed [gmo_pkg::VAL_W-1:0] rdata,
  output gmo_pkg::mbr_ctl_t               mctl,
  input  gmo_pkg::mbr_stat_t              mstat
);
  import gmo_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GATHER,
    S_UPD_RD,
    S_UPD_WR,
    S_COUNT,
    S_FINISH
  } state_t;

  state_t state;
  logic [GCNT_W-1:0]   cnt;
  logic                pend;
  logic [GIDX_W-1:0]   pidx;
  logic signed [SUM_W-1:0] sum;
  logic                all_neg;
  logic                all_pos;
  logic [ROUNDS_W-1:0] rounds;
  cause_t              cause;
  logic [ACNT_W-1:0]   qaddr;
  logic [ACNT_W-1:0]   qlim;
  logic                qpend;
  logic [ACNT_W-1:0]   negcnt;
  logic                out_valid;
  logic [ROUNDS_W-1:0] out_rounds;
  cause_t              out_cause;
  logic [ACNT_W-1:0]   out_neg;

  logic accept;
  logic rd_pos;
  logic issue;
  logic gather_done;
  logic early_stop;
  logic round_end;
  logic [ROUNDS_W-1:0] rounds_inc;
  logic limit_hit;
  logic qdone;
  logic [ACNT_W-1:0] qlim_new;
  logic signed [DELTA_W-1:0] sum_x;
  logic signed [DELTA_W-1:0] mult_x;
  logic signed [DELTA_W-1:0] delta;
  logic [VAL_W:0] upd_sum;
  logic signed [VAL_W-1:0] upd_val;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign rd_pos    = rdata > 0;
  assign issue     = cnt < mstat.total;
  assign gather_done = (state == S_GATHER) && !issue && !pend;
  // the end tests apply only after a round has run
  assign early_stop  = (rounds != '0) && (all_neg || all_pos);
  assign round_end   = (state == S_UPD_RD) && !issue;
  assign rounds_inc  = rounds + ROUNDS_W'(1);
  assign limit_hit   = rounds_inc >= cfg.max_rounds;
  assign qdone       = !(qaddr < qlim) && !qpend;
  assign qlim_new    = (cfg.agent_count > ACNT_W'(AGENTS_MAX)) ?
                       ACNT_W'(AGENTS_MAX) : cfg.agent_count;

  // delta of one member; without self influence its own occurrences drop out
  always_comb begin
    sum_x  = DELTA_W'(sum);
    mult_x = $signed({2'b00, mstat.mult});
    if (cfg.self_influence) begin
      delta = sum_x;
    end else if (mstat.sgn_pos) begin
      delta = sum_x - mult_x;
    end else begin
      delta = sum_x + mult_x;
    end
    upd_sum = {rdata[VAL_W-1], rdata} +
              {{(VAL_W-DELTA_W){delta[DELTA_W-1]}}, delta, 1'b0};
    if (upd_sum[VAL_W] != upd_sum[VAL_W-1]) begin
      upd_val = upd_sum[VAL_W] ? VAL_MIN : VAL_MAX;
    end else begin
      upd_val = $signed(upd_sum[VAL_W-1:0]);
    end
  end

  always_comb begin
    store.we    = (accept && (req.op == OP_LOAD)) || (state == S_UPD_WR);
    store.waddr = (state == S_UPD_WR) ? mstat.idx : req.agent_index;
    store.wdata = (state == S_UPD_WR) ? upd_val : req.agent_value;
    store.raddr = (state == S_COUNT) ? qaddr[AIDX_W-1:0] : mstat.idx;

    mctl.ins     = accept && (req.op == OP_MEMBER);
    mctl.ins_idx = req.agent_index;
    mctl.clear   = (gather_done && early_stop) || (round_end && limit_hit);
    mctl.sel     = cnt[GIDX_W-1:0];
    mctl.sgn_we  = (state == S_GATHER) && pend;
    mctl.sgn_sel = pidx;
    mctl.sgn_pos = rd_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pend      <= 1'b0;
      qpend     <= 1'b0;
    end else begin
      if (rsp.ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (op_t'(req.op))
              OP_MEMBER: begin
                if (req.last_member) begin
                  state   <= S_GATHER;
                  cnt     <= '0;
                  pend    <= 1'b0;
                  sum     <= '0;
                  all_neg <= 1'b1;
                  all_pos <= 1'b1;
                  rounds  <= '0;
                  negcnt  <= '0;
                end
              end
              OP_COUNT: begin
                state  <= S_COUNT;
                qaddr  <= '0;
                qlim   <= qlim_new;
                qpend  <= 1'b0;
                negcnt <= '0;
                rounds <= '0;
                cause  <= CAUSE_LIMIT;
              end
              default: begin
              end
            endcase
          end
        end
        S_GATHER: begin
          if (issue) begin
            cnt  <= cnt + GCNT_W'(1);
            pend <= 1'b1;
            pidx <= cnt[GIDX_W-1:0];
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            sum     <= rd_pos ? sum + SUM_W'(1) : sum - SUM_W'(1);
            all_neg <= all_neg & rdata[VAL_W-1];
            all_pos <= all_pos & rd_pos;
          end
          if (gather_done) begin
            if (early_stop) begin
              state <= S_FINISH;
              cause <= all_neg ? CAUSE_NEG : CAUSE_POS;
            end else begin
              state <= S_UPD_RD;
              cnt   <= '0;
            end
          end
        end
        S_UPD_RD: begin
          if (!issue) begin
            rounds <= rounds_inc;
            if (limit_hit) begin
              state <= S_FINISH;
              cause <= CAUSE_LIMIT;
            end else begin
              state   <= S_GATHER;
              cnt     <= '0;
              pend    <= 1'b0;
              sum     <= '0;
              all_neg <= 1'b1;
              all_pos <= 1'b1;
            end
          end else begin
            state <= S_UPD_WR;
          end
        end
        S_UPD_WR: begin
          cnt   <= cnt + GCNT_W'(1);
          state <= S_UPD_RD;
        end
        S_COUNT: begin
          if (qaddr < qlim) begin
            qaddr <= qaddr + ACNT_W'(1);
            qpend <= 1'b1;
          end else begin
            qpend <= 1'b0;
          end
          if (qpend) begin
            negcnt <= negcnt + ACNT_W'(rdata[VAL_W-1]);
          end
          if (qdone) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          // wait until the output register is free
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_rounds <= rounds;
            out_cause  <= cause;
            out_neg    <= negcnt;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.rounds_done    = out_rounds;
  assign rsp.end_cause      = out_cause;
  assign rsp.negative_count = out_neg;

endmodule

FILE: design/group_majority_opinion_update_core.sv
// top level: register port, opinion memory, member list and sequencer
// depends on gmo_pkg, gmo_if, gmo_store, gmo_members, gmo_ctrl
//
// channel   dir  handshake            payload
// req       in   valid/ready          op, agent_index, agent_value, last_member
// rsp       out  valid/ready          rounds_done, end_cause, negative_count
// apb       in   psel/penable/pready  paddr, pwdata, prdata
//
// load and non-closing member items are handled as they are taken.
// a closing member runs rounds over the n stored members: a gather pass,
// which can end the run, then an update pass, after which the round
// limit can end it; the result is then posted. all of it goes through
// the single read port of the opinion memory.
// a count query reads min(agent_count, 1024) entries, then posts the result.
// rst is synchronous and clears control state and registers; the opinion
// memory is not cleared. a result waits in the output register until taken.
module group_majority_opinion_update_core (
  input  logic                          clk,
  input  logic                          rst,
  gmo_req_if.sink                       req,
  gmo_rsp_if.source                     rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gmo_pkg::PADDR_W-1:0]   paddr,
  input  logic [gmo_pkg::PDATA_W-1:0]   pwdata,
  output logic [gmo_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import gmo_pkg::*;

  cfg_t       cfg;
  store_req_t store_req;
  mbr_ctl_t   mbr_ctl;
  mbr_stat_t  mbr_stat;
  logic signed [VAL_W-1:0] store_rdata;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_rounds     <= ROUNDS_W'(1);
      cfg.self_influence <= 1'b1;
      cfg.agent_count    <= ACNT_W'(1024);
    end else if (wr_en) begin
      case (reg_idx)
        REG_MAX_ROUNDS:  cfg.max_rounds     <= pwdata[ROUNDS_W-1:0];
        REG_SELF_INFL:   cfg.self_influence <= pwdata[0];
        REG_AGENT_COUNT: cfg.agent_count    <= pwdata[ACNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAX_ROUNDS:  prdata = PDATA_W'(cfg.max_rounds);
      REG_SELF_INFL:   prdata = PDATA_W'(cfg.self_influence);
      REG_AGENT_COUNT: prdata = PDATA_W'(cfg.agent_count);
      default:         prdata = '0;
    endcase
  end

  gmo_store u_store (
    .clk   (clk),
    .req   (store_req),
    .rdata (store_rdata)
  );

  gmo_members u_members (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mbr_ctl),
    .stat (mbr_stat)
  );

  gmo_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rsp   (rsp),
    .cfg   (cfg),
    .store (store_req),
    .rdata (store_rdata),
    .mctl  (mbr_ctl),
    .mstat (mbr_stat)
  );

`ifndef ASSERT_OFF
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    mbr_stat.total <= GCNT_W'(GROUP_MAX))
    else $error("member total beyond group size");

  a_no_stray_write: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && (req.op != OP_LOAD)) |-> !store_req.we)
    else $error("opinion write during a non-load item");

  a_close_busy: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && (req.op == OP_MEMBER) && req.last_member)
      |=> !req.ready)
    else $error("closing member did not start the rounds");

  a_clear_excl: assert property (@(posedge clk) disable iff (rst)
    mbr_ctl.clear |-> (!mbr_ctl.ins && !req.ready))
    else $error("group cleared while items are taken");
`endif

endmodule
